// File: sv/rmp_pkg.sv
// Shared types and constants for the routing message parser.
// Used by every module of the block; depends on nothing.
package rmp_pkg;

	// Message layout and checksum constants.
	localparam int unsigned HEADER_LEN  = 4;
	localparam int unsigned MIN_LEN     = 6;
	localparam int unsigned HOP_SHIFT   = 10;
	localparam logic [15:0] SUM_SEED    = 16'h0001;
	localparam logic [15:0] SUM_MASK    = 16'hFFFF;
	localparam logic [9:0]  COST_MASK   = 10'h3FF;

	// Default depth of the queue between front and back.
	localparam int unsigned QUEUE_DEPTH = 4;

	// Result kinds.
	localparam logic KIND_ENTRY  = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	// Status codes.
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_SHORT    = 2'd1;
	localparam logic [1:0] ST_SEG_ERR  = 2'd2;
	localparam logic [1:0] ST_MISMATCH = 2'd3;

	// One input item.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       final_byte;
	} in_item_t;

	// One result item.
	typedef struct packed {
		logic        result_kind;
		logic [15:0] node_index;
		logic [5:0]  hop_count;
		logic [9:0]  path_cost;
		logic [1:0]  status;
		logic [15:0] source_id;
		logic [7:0]  message_flags;
		logic [15:0] segments_seen;
		logic        end_of_run;
	} out_item_t;

	// Work handed from the front to the back through the queue.
	typedef struct packed {
		logic        has_body;   // a body byte has been released
		logic [7:0]  body;       // the released body byte
		logic        fin;        // last byte of the message
		logic        too_short;  // message shorter than the minimum length
		logic [15:0] given_sum;  // checksum carried in the two held bytes
	} body_cmd_t;

endpackage

// File: sv/routing_message_parser_top.sv
// Routing message parser: one message byte per item in, routing entries and one
// status per message out. A front stage holds back the two newest bytes so the
// trailing checksum is never parsed as body, and passes released bytes through a
// short queue (QUEUE_DEPTH commands) to a back stage that walks the header and
// segments, keeps the end-around-carry checksum and fills a result register.
// A byte is accepted every cycle while the queue has room; a byte yields at most
// one result, except a final byte that also completes a routing word, which
// occupies the back stage for an entry and then a status. A byte's command is
// stored in the queue, and its result is then held in the result register.
// Entries are emitted before the verdict and are valid only if the status reads ok.
module routing_message_parser_top #(
	parameter int unsigned QUEUE_DEPTH = rmp_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               byte_valid,
	output logic               byte_ready,
	input  rmp_pkg::in_item_t  byte_item,
	output logic               res_valid,
	input  logic               res_ready,
	output rmp_pkg::out_item_t res_item
);

	logic               push_valid;
	logic               push_ready;
	rmp_pkg::body_cmd_t push_cmd;
	logic               head_valid;
	logic               pop;
	rmp_pkg::body_cmd_t head_cmd;

	// Byte intake and hold-back.
	rmp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.byte_item  (byte_item),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	// Decoupling queue.
	rmp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.head_valid (head_valid),
		.pop        (pop),
		.head_cmd   (head_cmd)
	);

	// Parsing, checksum and result generation.
	rmp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res_item   (res_item)
	);

endmodule

// File: sv/rmp_front.sv
// Front part of the routing message parser: accepts bytes and holds back two.
// Depends on rmp_pkg; feeds rmp_queue with rmp_pkg::body_cmd_t commands.
module rmp_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               byte_valid,
	output logic               byte_ready,
	input  rmp_pkg::in_item_t  byte_item,
	output logic               push_valid,
	input  logic               push_ready,
	output rmp_pkg::body_cmd_t push_cmd
);

	localparam int unsigned POS_W = $clog2(rmp_pkg::MIN_LEN + 1);
	localparam logic [POS_W-1:0] POS_MAX = POS_W'(rmp_pkg::MIN_LEN);

	logic [1:0]       held_cnt_q;
	logic [7:0]       held0_q;
	logic [7:0]       held1_q;
	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] pos_n;
	logic [7:0]       held0_n;
	logic [7:0]       held1_n;
	logic             accept;

	assign byte_ready = push_ready;
	assign accept     = byte_valid && byte_ready;

	// Byte count, saturating once the minimum length is reached.
	assign pos_n = (pos_q == POS_MAX) ? pos_q : pos_q + POS_W'(1);

	// Held bytes after this item: the oldest drops out once two are held.
	always_comb begin
		held0_n = held0_q;
		held1_n = held1_q;
		if (held_cnt_q == 2'd2) begin
			held0_n = held1_q;
			held1_n = byte_item.data_byte;
		end else if (held_cnt_q == 2'd1) begin
			held1_n = byte_item.data_byte;
		end else begin
			held0_n = byte_item.data_byte;
		end
	end

	// A command is needed only when a body byte is released or the message ends.
	assign push_valid         = byte_valid && ((held_cnt_q == 2'd2) || byte_item.final_byte);
	assign push_cmd.has_body  = (held_cnt_q == 2'd2);
	assign push_cmd.body      = held0_q;
	assign push_cmd.fin       = byte_item.final_byte;
	assign push_cmd.too_short = (pos_n < POS_MAX);
	assign push_cmd.given_sum = {held1_n, held0_n};

	// Hold-back registers; the count and position restart after the last byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_cnt_q <= 2'd0;
			pos_q      <= '0;
		end else if (accept) begin
			if (byte_item.final_byte) begin
				held_cnt_q <= 2'd0;
				pos_q      <= '0;
			end else begin
				held_cnt_q <= (held_cnt_q == 2'd2) ? held_cnt_q : held_cnt_q + 2'd1;
				pos_q      <= pos_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			held0_q <= held0_n;
			held1_q <= held1_n;
		end
	end

endmodule

// File: sv/rmp_queue.sv
// Short first-in first-out queue of commands between front and back.
// Depends on rmp_pkg for the command type.
module rmp_queue #(
	parameter int unsigned DEPTH = rmp_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_valid,
	output logic               push_ready,
	input  rmp_pkg::body_cmd_t push_cmd,
	output logic               head_valid,
	input  logic               pop,
	output rmp_pkg::body_cmd_t head_cmd
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	rmp_pkg::body_cmd_t mem [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               push;

	assign push_ready = (count_q != CNT_FULL);
	assign head_valid = (count_q != '0);
	assign head_cmd   = mem[rd_ptr_q];
	assign push       = push_valid && push_ready;

	// Storage write.
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// File: sv/rmp_back.sv
// Back part of the routing message parser: segment parsing, checksum and results.
// Depends on rmp_pkg; takes commands from rmp_queue and drives the result register.
module rmp_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                head_valid,
	input  rmp_pkg::body_cmd_t  head_cmd,
	output logic                pop,
	output logic                res_valid,
	input  logic                res_ready,
	output rmp_pkg::out_item_t  res_item
);

	// Parse phases.
	localparam logic [2:0] PH_HEADER   = 3'd0;
	localparam logic [2:0] PH_COUNT_LO = 3'd1;
	localparam logic [2:0] PH_COUNT_HI = 3'd2;
	localparam logic [2:0] PH_START_LO = 3'd3;
	localparam logic [2:0] PH_START_HI = 3'd4;
	localparam logic [2:0] PH_WORD_LO  = 3'd5;
	localparam logic [2:0] PH_WORD_HI  = 3'd6;

	localparam logic [1:0] HDR_LAST = 2'(rmp_pkg::HEADER_LEN - 1);

	logic [2:0]  phase_q, phase_n;
	logic [1:0]  hdr_q, hdr_n;
	logic [15:0] words_q, words_n;
	logic [15:0] index_q, index_n;
	logic [7:0]  low_q, low_n;
	logic [15:0] sum_q, sum_n;
	logic [7:0]  flags_q, flags_n;
	logic [15:0] src_q, src_n;
	logic [15:0] tally_q, tally_n;
	logic        done_q;

	rmp_pkg::out_item_t out_q;
	logic               out_valid_q;

	logic [15:0] word;
	logic [16:0] sum_add;
	logic [15:0] sum_eac;
	logic [15:0] tally_inc;
	logic        apply;
	logic        is_entry;
	logic        emit_status;
	logic        take;
	logic [1:0]  status_code;

	// The routing word being completed and its end-around-carry sum.
	assign word      = {head_cmd.body, low_q};
	assign sum_add   = {1'b0, sum_q} + {1'b0, word};
	assign sum_eac   = sum_add[15:0] + {15'd0, sum_add[16]};
	assign tally_inc = (tally_q == rmp_pkg::SUM_MASK) ? tally_q : tally_q + 16'd1;

	// The body byte is applied once, even when its command stays for the status.
	assign apply = head_cmd.has_body && !done_q;

	// One step of the parse phase sequence.
	always_comb begin
		phase_n  = phase_q;
		hdr_n    = hdr_q;
		words_n  = words_q;
		index_n  = index_q;
		low_n    = low_q;
		sum_n    = sum_q;
		flags_n  = flags_q;
		src_n    = src_q;
		tally_n  = tally_q;
		is_entry = 1'b0;
		if (apply) begin
			case (phase_q)
				PH_HEADER: begin
					case (hdr_q)
						2'd0:    flags_n = head_cmd.body;
						2'd1:    src_n[7:0] = head_cmd.body;
						2'd2:    src_n[15:8] = head_cmd.body;
						default: ;
					endcase
					hdr_n = hdr_q + 2'd1;
					if (hdr_q == HDR_LAST) begin
						phase_n = PH_COUNT_LO;
					end
				end
				PH_COUNT_LO, PH_START_LO, PH_WORD_LO: begin
					low_n   = head_cmd.body;
					phase_n = phase_q + 3'd1;
				end
				PH_COUNT_HI: begin
					words_n = word;
					sum_n   = sum_eac;
					phase_n = PH_START_LO;
				end
				PH_START_HI: begin
					index_n = word;
					sum_n   = sum_eac;
					if (words_q == 16'd0) begin
						tally_n = tally_inc;
						phase_n = PH_COUNT_LO;
					end else begin
						phase_n = PH_WORD_LO;
					end
				end
				PH_WORD_HI: begin
					sum_n    = sum_eac;
					is_entry = 1'b1;
					index_n  = index_q + 16'd1;
					words_n  = words_q - 16'd1;
					if (words_q == 16'd1) begin
						tally_n = tally_inc;
						phase_n = PH_COUNT_LO;
					end else begin
						phase_n = PH_WORD_LO;
					end
				end
				default: phase_n = PH_HEADER;
			endcase
		end
	end

	// Verdict on the message, taken after the last body byte is applied.
	always_comb begin
		if (head_cmd.too_short) begin
			status_code = rmp_pkg::ST_SHORT;
		end else if (phase_n != PH_COUNT_LO) begin
			status_code = rmp_pkg::ST_SEG_ERR;
		end else if (head_cmd.given_sum != sum_n) begin
			status_code = rmp_pkg::ST_MISMATCH;
		end else begin
			status_code = rmp_pkg::ST_OK;
		end
	end

	// A command is taken when the result register is free or being emptied.
	// A final item that also completes a word stays at the head for its status.
	assign take        = head_valid && (!out_valid_q || res_ready);
	assign emit_status = head_cmd.fin && !is_entry;
	assign pop         = take && !(is_entry && head_cmd.fin);

	// Parse state; everything returns to its reset value after the status.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			hdr_q   <= 2'd0;
			words_q <= 16'd0;
			index_q <= 16'd0;
			low_q   <= 8'd0;
			sum_q   <= rmp_pkg::SUM_SEED;
			flags_q <= 8'd0;
			src_q   <= 16'd0;
			tally_q <= 16'd0;
			done_q  <= 1'b0;
		end else if (take) begin
			if (emit_status) begin
				phase_q <= PH_HEADER;
				hdr_q   <= 2'd0;
				words_q <= 16'd0;
				index_q <= 16'd0;
				low_q   <= 8'd0;
				sum_q   <= rmp_pkg::SUM_SEED;
				flags_q <= 8'd0;
				src_q   <= 16'd0;
				tally_q <= 16'd0;
			end else begin
				phase_q <= phase_n;
				hdr_q   <= hdr_n;
				words_q <= words_n;
				index_q <= index_n;
				low_q   <= low_n;
				sum_q   <= sum_n;
				flags_q <= flags_n;
				src_q   <= src_n;
				tally_q <= tally_n;
			end
			done_q <= is_entry && head_cmd.fin;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= is_entry || emit_status;
		end else if (res_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			if (is_entry) begin
				out_q.result_kind   <= rmp_pkg::KIND_ENTRY;
				out_q.node_index    <= index_q;
				out_q.hop_count     <= word[15:rmp_pkg::HOP_SHIFT];
				out_q.path_cost     <= word[rmp_pkg::HOP_SHIFT-1:0] & rmp_pkg::COST_MASK;
				out_q.status        <= rmp_pkg::ST_OK;
				out_q.source_id     <= 16'd0;
				out_q.message_flags <= 8'd0;
				out_q.segments_seen <= 16'd0;
				out_q.end_of_run    <= !head_cmd.fin;
			end else begin
				out_q.result_kind   <= rmp_pkg::KIND_STATUS;
				out_q.node_index    <= 16'd0;
				out_q.hop_count     <= 6'd0;
				out_q.path_cost     <= 10'd0;
				out_q.status        <= status_code;
				out_q.source_id     <= src_n;
				out_q.message_flags <= flags_n;
				out_q.segments_seen <= tally_n;
				out_q.end_of_run    <= 1'b1;
			end
		end
	end

	assign res_valid = out_valid_q;
	assign res_item  = out_q;

	// A command kept back for its status must still be at the head of the queue.
	a_done_holds_head: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> head_valid)
		else $error("kept-back command missing from the queue");

	// The status is kept back only behind an entry that does not end the run.
	a_done_after_entry: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(done_q) |-> out_valid_q && out_q.result_kind == rmp_pkg::KIND_ENTRY
			&& !out_q.end_of_run)
		else $error("status deferred without a preceding entry");

	// Every status result closes its run.
	a_status_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.result_kind == rmp_pkg::KIND_STATUS |-> out_q.end_of_run)
		else $error("status result without end of run");

	// After a status the parser starts a fresh message.
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		take && emit_status |=> phase_q == PH_HEADER && sum_q == rmp_pkg::SUM_SEED
			&& !done_q)
		else $error("parser not restarted after status");

endmodule
